// ----- src/hfcu_pkg.sv -----
// ----------------------------------------------------------------------------
// hfcu_pkg
// Shared constants, types and helper functions of the hex frame CRC unpacker.
// ----------------------------------------------------------------------------
package hfcu_pkg;

    // Default sizes and saturation limits
    localparam int FRAME_BYTES_DEF = 32;
    localparam int COIL_TOP_DEF    = 63;
    localparam int REG_TOP_DEF     = 70;

    // Pointer registers cover the full limit range
    localparam int PTR_W = 8;

    // Operation codes
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_BYTE  = 2'd1;
    localparam logic [1:0] OP_END   = 2'd2;
    localparam logic [1:0] OP_ROUND = 2'd3;

    // Module kinds
    localparam logic [2:0] KIND_DCNT = 3'd1;
    localparam logic [2:0] KIND_DIG  = 3'd2;
    localparam logic [2:0] KIND_CUR  = 3'd3;
    localparam logic [2:0] KIND_RTD  = 3'd4;

    // Decode walk: bytes 1..LAST_IDX are read, nibbles of bytes 1..NIB_CNT kept
    localparam int         IDX_W    = 5;
    localparam logic [4:0] LAST_IDX = 5'd22;
    localparam logic [4:0] NIB_LAST = 5'd18;
    localparam int         NIB_CNT  = 18;
    localparam int         VEC_W    = 4 * NIB_CNT;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Controller to datapath commands
    typedef struct packed {
        logic             start;
        logic             rd_en;
        logic [IDX_W-1:0] rd_idx;
        logic             emit;
        logic [3:0]       k;
        logic             last;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic       out_free;
        logic [3:0] n_res;
    } t_stat;

    // One entry of the reflected CRC-16 byte table
    function automatic logic [15:0] crc_entry(input logic [7:0] b);
        logic [15:0] c;
        c = {8'h00, b};
        for (int j = 0; j < 8; j++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Character to nibble, other characters keep the low four bits of c - 0x30 or c - 0x37
    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [7:0] v;
        v = (c <= 8'h39) ? (c - 8'h30) : (c - 8'h37);
        return v[3:0];
    endfunction

    // Nibble to upper-case hex character
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        return (n <= 4'd9) ? (8'h30 + {4'h0, n}) : (8'h37 + {4'h0, n});
    endfunction

    // Frame length per kind
    function automatic logic [IDX_W-1:0] frame_len(input logic [2:0] kind);
        logic [IDX_W-1:0] len;
        case (kind)
            KIND_DCNT: len = 5'd11;
            KIND_DIG:  len = 5'd7;
            KIND_CUR:  len = 5'd22;
            KIND_RTD:  len = 5'd12;
            default:   len = 5'd5;
        endcase
        return len;
    endfunction

    // Number of writes per kind
    function automatic logic [3:0] result_count(input logic [2:0] kind);
        logic [3:0] n;
        case (kind)
            KIND_DCNT: n = 4'd12;
            KIND_DIG:  n = 4'd12;
            KIND_CUR:  n = 4'd6;
            KIND_RTD:  n = 4'd4;
            default:   n = 4'd0;
        endcase
        return n;
    endfunction

endpackage

// ----- src/hfcu_if.sv -----
// ----------------------------------------------------------------------------
// hfcu_in_if / hfcu_out_if
// Valid/ready channels of the hex frame CRC unpacker.
// ----------------------------------------------------------------------------
interface hfcu_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] rx_byte;
    logic [2:0] module_kind;

    modport source (output valid, output operation, output rx_byte, output module_kind,
                    input ready);
    modport sink   (input valid, input operation, input rx_byte, input module_kind,
                    output ready);
endinterface

interface hfcu_out_if;
    logic        valid;
    logic        ready;
    logic        is_register;
    logic [6:0]  target_index;
    logic [15:0] write_value;
    logic        crc_failed;
    logic        last;

    modport source (output valid, output is_register, output target_index,
                    output write_value, output crc_failed, output last, input ready);
    modport sink   (input valid, input is_register, input target_index,
                    input write_value, input crc_failed, input last, output ready);
endinterface

// ----- src/hfcu_ctrl.sv -----
// ----------------------------------------------------------------------------
// hfcu_ctrl
// Sequencer: takes transactions, walks the frame store, paces the writes.
// ----------------------------------------------------------------------------
module hfcu_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic [1:0]         i_op,
    output logic               o_in_ready,
    input  hfcu_pkg::t_stat    i_stat,
    output hfcu_pkg::t_cmd     o_cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_READ  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0]                 r_state, n_state;
    logic [hfcu_pkg::IDX_W-1:0] r_idx, n_idx;
    logic [3:0]                 r_k, n_k;
    logic                       w_last;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_last     = (r_k == (i_stat.n_res - 4'd1));

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_k     = r_k;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_op == hfcu_pkg::OP_END) begin
                    o_cmd.start = 1'b1;
                    n_idx       = 5'd1;
                    n_state     = ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_idx = r_idx;
                if (r_idx == hfcu_pkg::LAST_IDX) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_idx = r_idx + 5'd1;
                end
            end
            ST_DRAIN: begin
                n_k     = 4'd0;
                n_state = (i_stat.n_res == 4'd0) ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.k    = r_k;
                    o_cmd.last = w_last;
                    if (w_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_k = r_k + 4'd1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_k     <= n_k;
        end
    end

endmodule

// ----- src/hfcu_dpath.sv -----
// ----------------------------------------------------------------------------
// hfcu_dpath
// Frame store, CRC accumulator, nibble buffer, write pointers, output register.
// ----------------------------------------------------------------------------
module hfcu_dpath #(
    parameter int FRAME_BYTES = hfcu_pkg::FRAME_BYTES_DEF,
    parameter int COIL_TOP    = hfcu_pkg::COIL_TOP_DEF,
    parameter int REG_TOP     = hfcu_pkg::REG_TOP_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [1:0]         i_op,
    input  logic [7:0]         i_rx_byte,
    input  logic [2:0]         i_kind,
    input  hfcu_pkg::t_cmd     i_cmd,
    output hfcu_pkg::t_stat    o_stat,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic               o_is_register,
    output logic [6:0]         o_target_index,
    output logic [15:0]        o_write_value,
    output logic               o_crc_failed,
    output logic               o_last
);

    localparam int ADDR_W = $clog2(FRAME_BYTES);
    localparam int CNT_W  = $clog2(FRAME_BYTES + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FRAME_BYTES);
    localparam logic [hfcu_pkg::PTR_W-1:0] COIL_LIM = hfcu_pkg::PTR_W'(COIL_TOP);
    localparam logic [hfcu_pkg::PTR_W-1:0] REG_LIM  = hfcu_pkg::PTR_W'(REG_TOP);
    localparam int VW = hfcu_pkg::VEC_W;

    logic [7:0]                  r_mem [FRAME_BYTES];
    logic [FRAME_BYTES-1:0]      r_vld;
    logic [CNT_W-1:0]            r_cnt;
    logic [2:0]                  r_kind;
    logic [7:0]                  r_rd_data;
    logic                        r_rd_ok;
    logic                        r_rd_vld;
    logic [hfcu_pkg::IDX_W-1:0]  r_rd_idx;
    logic [15:0]                 r_crc;
    logic                        r_fail;
    logic [VW-1:0]               r_vec;
    logic [hfcu_pkg::PTR_W-1:0]  r_coil_ptr, r_reg_ptr;
    logic                        r_out_vld;

    logic                        w_wr;
    logic [ADDR_W-1:0]           w_rd_addr;
    logic [7:0]                  w_byte;
    logic [hfcu_pkg::IDX_W-1:0]  w_len;
    logic [hfcu_pkg::IDX_W-1:0]  w_pos;
    logic [3:0]                  w_crc_nib;
    logic                        w_is_coil_kind;
    logic                        w_is_reg;
    logic [15:0]                 w_value;

    assign w_wr      = i_accept && (i_op == hfcu_pkg::OP_BYTE) && (r_cnt < CNT_FULL);
    assign w_rd_addr = ADDR_W'(i_cmd.rd_idx);
    assign w_byte    = r_rd_ok ? r_rd_data : 8'h00;
    assign w_len     = hfcu_pkg::frame_len(r_kind);
    assign w_pos     = r_rd_idx - (w_len - 5'd3);

    // Pick the expected CRC digit, most significant first
    always_comb begin
        case (w_pos[1:0])
            2'd0:    w_crc_nib = r_crc[15:12];
            2'd1:    w_crc_nib = r_crc[11:8];
            2'd2:    w_crc_nib = r_crc[7:4];
            default: w_crc_nib = r_crc[3:0];
        endcase
    end

    // Select the write value for the current result
    assign w_is_coil_kind = (r_kind == hfcu_pkg::KIND_DCNT) || (r_kind == hfcu_pkg::KIND_DIG);
    always_comb begin
        w_is_reg = 1'b1;
        w_value  = 16'h0000;
        if (w_is_coil_kind) begin
            if (r_kind == hfcu_pkg::KIND_DCNT && i_cmd.k == 4'd11) begin
                w_value = r_vec[VW-13 -: 16];
            end else begin
                w_is_reg = 1'b0;
                w_value  = {15'h0000, r_vec[VW-1]};
            end
        end else if (r_kind == hfcu_pkg::KIND_CUR) begin
            w_value = {4'h0, r_vec[VW-1 -: 12]};
        end else begin
            w_value = {8'h00, r_vec[VW-1 -: 8]};
        end
    end

    // Frame store write and registered read
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_cnt[ADDR_W-1:0]] <= i_rx_byte;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_crc  <= hfcu_pkg::CRC_INIT;
            r_fail <= 1'b0;
        end else if (r_rd_vld) begin
            if (r_rd_idx <= w_len - 5'd4) begin
                r_crc <= (r_crc >> 8) ^ hfcu_pkg::crc_entry(r_crc[7:0] ^ w_byte);
            end else if (r_rd_idx <= w_len) begin
                if (hfcu_pkg::hex_char(w_crc_nib) != w_byte) begin
                    r_fail <= 1'b1;
                end
            end
        end
        if (r_rd_vld && r_rd_idx <= hfcu_pkg::NIB_LAST) begin
            r_vec <= {r_vec[VW-5:0], hfcu_pkg::nibble_of(w_byte)};
        end else if (i_cmd.emit) begin
            if (!w_is_reg) begin
                r_vec[VW-1 -: 12] <= {r_vec[VW-2 -: 11], 1'b0};
            end else if (r_kind == hfcu_pkg::KIND_CUR) begin
                r_vec <= {r_vec[VW-13:0], 12'h000};
            end else if (r_kind == hfcu_pkg::KIND_RTD) begin
                r_vec <= {r_vec[VW-9:0], 8'h00};
            end
        end
        r_rd_ok  <= r_vld[w_rd_addr];
        r_rd_idx <= i_cmd.rd_idx;
        if (i_cmd.emit) begin
            o_is_register  <= w_is_reg;
            o_target_index <= w_is_reg ? r_reg_ptr[6:0] : r_coil_ptr[6:0];
            o_write_value  <= r_fail ? 16'h0000 : w_value;
            o_crc_failed   <= r_fail;
            o_last         <= i_cmd.last;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_cnt      <= '0;
            r_kind     <= '0;
            r_rd_vld   <= 1'b0;
            r_coil_ptr <= 8'd1;
            r_reg_ptr  <= 8'd2;
            r_out_vld  <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd_en;
            // Window control
            if (i_accept && i_op == hfcu_pkg::OP_START) begin
                r_vld  <= '0;
                r_cnt  <= '0;
                r_kind <= i_kind;
            end else if (i_accept && i_op == hfcu_pkg::OP_END) begin
                r_cnt <= '0;
            end else if (w_wr) begin
                r_vld[r_cnt[ADDR_W-1:0]] <= 1'b1;
                r_cnt <= r_cnt + 1'b1;
            end
            // Rewind on start round, else advance and saturate write pointers
            if (i_accept && i_op == hfcu_pkg::OP_ROUND) begin
                r_coil_ptr <= 8'd1;
                r_reg_ptr  <= 8'd2;
            end else if (i_cmd.emit) begin
                if (w_is_reg) begin
                    if (r_reg_ptr < REG_LIM) begin
                        r_reg_ptr <= r_reg_ptr + 8'd1;
                    end
                end else if (r_coil_ptr < COIL_LIM) begin
                    r_coil_ptr <= r_coil_ptr + 8'd1;
                end
            end
            // Output slot
            if (i_cmd.emit) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_stat.out_free = !r_out_vld || i_out_ready;
    assign o_stat.n_res    = hfcu_pkg::result_count(r_kind);

endmodule

// ----- src/hex_frame_crc_unpacker.sv -----
// ----------------------------------------------------------------------------
// hex_frame_crc_unpacker
// Collects an ASCII reply frame, checks its CRC-16 and unpacks coil/register
// writes from its hex digits.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one operation per transaction: start window (clears the
//   frame store, latches the module kind), received byte (stored while the
//   store has room), end window (decode) and start round (rewinds the coil
//   and register pointers).
//   Start window, byte and start round leave ready high.
//   End window walks bytes 1..22 of the store through its single read port,
//   one byte per cycle, updating the CRC and buffering nibbles, then
//   finishes the last byte in a drain state: ready is low throughout and
//   stays low while the writes are issued. The writes then follow one per
//   cycle while the output slot is free (4, 6 or 12 writes; none for an
//   unknown kind).
//   o_out holds each write in an output register; a stalled receiver freezes
//   the write sequence, and the last write may wait while i_in takes new
//   transactions.
//   Reset empties the store, clears the byte count and kind, sets the coil
//   pointer to 1 and the register pointer to 2, and drops o_out.valid.
// ----------------------------------------------------------------------------
module hex_frame_crc_unpacker #(
    parameter int FRAME_BYTES = hfcu_pkg::FRAME_BYTES_DEF,
    parameter int COIL_TOP    = hfcu_pkg::COIL_TOP_DEF,
    parameter int REG_TOP     = hfcu_pkg::REG_TOP_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hfcu_in_if.sink     i_in,
    hfcu_out_if.source  o_out
);

    hfcu_pkg::t_cmd  w_cmd;
    hfcu_pkg::t_stat w_stat;
    logic            w_in_ready;
    logic            w_accept;

    assign i_in.ready = w_in_ready;
    assign w_accept   = i_in.valid && w_in_ready;

    // Sequencer
    hfcu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_op       (i_in.operation),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Datapath
    hfcu_dpath #(
        .FRAME_BYTES (FRAME_BYTES),
        .COIL_TOP    (COIL_TOP),
        .REG_TOP     (REG_TOP)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_op           (i_in.operation),
        .i_rx_byte      (i_in.rx_byte),
        .i_kind         (i_in.module_kind),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_is_register  (o_out.is_register),
        .o_target_index (o_out.target_index),
        .o_write_value  (o_out.write_value),
        .o_crc_failed   (o_out.crc_failed),
        .o_last         (o_out.last)
    );

endmodule

// ----- src/hfcu_checker.sv -----
// ----------------------------------------------------------------------------
// hfcu_checker
// Port-level checks of the hex frame CRC unpacker, bound to the top level.
// ----------------------------------------------------------------------------
module hfcu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic [1:0]  i_in_op,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_is_register,
    input logic [6:0]  i_target_index,
    input logic [15:0] i_write_value,
    input logic        i_crc_failed
);

    // Hold a stalled write
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_write_value))
        else $error("output transaction changed while stalled");

    // Drop ready once a decode starts
    a_end_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_op == hfcu_pkg::OP_END |=> !i_in_ready)
        else $error("input taken during decode");

    // Zero value on a failed CRC
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_crc_failed |-> i_write_value == 16'h0000)
        else $error("nonzero value on CRC failure");

    // Coil numbers start at one, register numbers at two
    a_index_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_is_register ? i_target_index >= 7'd2 : i_target_index >= 7'd1))
        else $error("target index below its start value");

endmodule

bind hex_frame_crc_unpacker hfcu_checker u_hfcu_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_in_op        (i_in.operation),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_is_register  (o_out.is_register),
    .i_target_index (o_out.target_index),
    .i_write_value  (o_out.write_value),
    .i_crc_failed   (o_out.crc_failed)
);

// ----- tb/hfcu_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hfcu_scoreboard
// Watches both channels of the unpacker, predicts the coil and register
// writes of every end-window transaction and compares them in order.
// ----------------------------------------------------------------------------
module hfcu_scoreboard (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hfcu_in_if.sink     i_in_mon,
    hfcu_out_if.sink    i_out_mon,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic        is_register;
        logic [6:0]  target_index;
        logic [15:0] write_value;
        logic        crc_failed;
        logic        last;
    } t_write;

    t_write      write_q[$];
    logic [7:0]  frame_mem[hfcu_pkg::FRAME_BYTES_DEF];
    int          byte_cnt;
    logic [2:0]  kind_hold;
    int          coil_ptr;
    int          reg_ptr;
    logic [15:0] crc_tab[256];

    function automatic logic [7:0] mem_at(input int idx);
        return (idx < hfcu_pkg::FRAME_BYTES_DEF) ? frame_mem[idx] : 8'h00;
    endfunction

    function automatic logic [3:0] nib(input int idx);
        logic [7:0] c;
        c = mem_at(idx);
        return (c <= 8'h39) ? 4'(c - 8'h30) : 4'(c - 8'h41 + 8'd10);
    endfunction

    function automatic logic [7:0] hexc(input logic [3:0] n);
        return (n <= 4'd9) ? 8'h30 + 8'(n) : 8'h41 - 8'd10 + 8'(n);
    endfunction

    // Queue one write and advance the saturating pointer
    task automatic push_write(input logic isreg, input logic [15:0] val, input logic bad);
        t_write w;
        w.is_register  = isreg;
        w.crc_failed   = bad;
        w.write_value  = bad ? 16'h0 : val;
        w.last         = 1'b0;
        if (isreg) begin
            w.target_index = 7'(reg_ptr);
            if (reg_ptr < hfcu_pkg::REG_TOP_DEF) reg_ptr++;
        end else begin
            w.target_index = 7'(coil_ptr);
            if (coil_ptr < hfcu_pkg::COIL_TOP_DEF) coil_ptr++;
        end
        write_q.push_back(w);
    endtask

    // Check the CRC and queue the writes of one frame
    task automatic decode_frame();
        int          len;
        int          n0;
        logic [15:0] crc;
        logic        bad;
        logic [3:0]  v;
        n0  = write_q.size();
        crc = 16'hFFFF;
        bad = 1'b0;
        case (kind_hold)
            hfcu_pkg::KIND_DCNT: len = 11;
            hfcu_pkg::KIND_DIG:  len = 7;
            hfcu_pkg::KIND_CUR:  len = 22;
            hfcu_pkg::KIND_RTD:  len = 12;
            default:             len = 5;
        endcase
        for (int i = 1; i <= len - 4; i++)
            crc = (crc >> 8) ^ crc_tab[(crc ^ 16'(mem_at(i))) & 16'hFF];
        for (int i = 0; i < 4; i++)
            if (hexc(4'(crc >> (12 - 4 * i))) != mem_at(len - 3 + i)) bad = 1'b1;
        if (kind_hold == hfcu_pkg::KIND_DCNT || kind_hold == hfcu_pkg::KIND_DIG) begin
            for (int i = 1; i < 4; i++) begin
                v = nib(i);
                for (int j = 0; j < 4; j++)
                    if (!(kind_hold == hfcu_pkg::KIND_DCNT && i == 3 && j == 3))
                        push_write(1'b0, 16'(v[3 - j]), bad);
            end
            if (kind_hold == hfcu_pkg::KIND_DCNT)
                push_write(1'b1, {nib(4), nib(5), nib(6), nib(7)}, bad);
        end else if (kind_hold == hfcu_pkg::KIND_CUR) begin
            for (int k = 1; k < 19; k += 3)
                push_write(1'b1, {4'h0, nib(k), nib(k + 1), nib(k + 2)}, bad);
        end else if (kind_hold == hfcu_pkg::KIND_RTD) begin
            for (int k = 1; k < 9; k += 2)
                push_write(1'b1, {8'h0, nib(k), nib(k + 1)}, bad);
        end
        if (write_q.size() > n0) write_q[$].last = 1'b1;
    endtask

    initial begin
        logic [15:0] c;
        for (int i = 0; i < 256; i++) begin
            c = 16'(i);
            for (int j = 0; j < 8; j++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
            crc_tab[i] = c;
        end
    end

    // Compare outputs against the oldest expected write, then track inputs
    always @(posedge i_clk) begin
        t_write got;
        t_write exp_w;
        if (!i_rst_n) begin
            foreach (frame_mem[i]) frame_mem[i] = 8'h00;
            byte_cnt     = 0;
            kind_hold    = 3'd0;
            coil_ptr     = 1;
            reg_ptr      = 2;
            o_fail_count = 0;
            write_q.delete();
        end else begin
            if (i_out_mon.valid && i_out_mon.ready) begin
                got = {i_out_mon.is_register, i_out_mon.target_index,
                       i_out_mon.write_value, i_out_mon.crc_failed, i_out_mon.last};
                if (write_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("unexpected write: %p", got);
                end else begin
                    exp_w = write_q.pop_front();
                    if (got != exp_w) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("write mismatch: expected %p actual %p", exp_w, got);
                    end
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                case (i_in_mon.operation)
                    hfcu_pkg::OP_START: begin
                        foreach (frame_mem[i]) frame_mem[i] = 8'h00;
                        byte_cnt  = 0;
                        kind_hold = i_in_mon.module_kind;
                    end
                    hfcu_pkg::OP_BYTE: begin
                        if (byte_cnt < hfcu_pkg::FRAME_BYTES_DEF) begin
                            frame_mem[byte_cnt] = i_in_mon.rx_byte;
                            byte_cnt++;
                        end
                    end
                    hfcu_pkg::OP_END: begin
                        byte_cnt = 0;
                        decode_frame();
                    end
                    default: begin
                        coil_ptr = 1;
                        reg_ptr  = 2;
                    end
                endcase
            end
        end
        o_pending = write_q.size();
    end

endmodule

// ----- tb/hex_frame_crc_unpacker_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hex_frame_crc_unpacker_test
// Sends directed and random reply frames, good and corrupted, through the
// unpacker with random gaps and receiver stalls; a checker scores the writes.
// ----------------------------------------------------------------------------
module hex_frame_crc_unpacker_test;

    localparam int CYCLE_LIMIT = 400000;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   cycle_cnt;
    bit   hold_off;
    int   sent;

    hfcu_in_if  in_ch();
    hfcu_out_if out_ch();

    hex_frame_crc_unpacker i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    hfcu_scoreboard i_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch.sink),
        .i_out_mon    (out_ch.sink),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("hex_frame_crc_unpacker_test: FAIL");
            $finish;
        end
    end

    // Stall the receiver on its own pattern, with one long hold-off
    initial begin
        int mode;
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                out_ch.ready <= 1'b0;
                repeat (300) @(negedge i_clk);
                hold_off = 1'b0;
            end
            mode = (cycle_cnt / 500) % 3;
            if (mode == 0) out_ch.ready <= 1'b1;
            else if (mode == 1) out_ch.ready <= ($urandom_range(0, 3) != 0);
            else out_ch.ready <= ($urandom_range(0, 1) == 1);
        end
    end

    // Offer one transaction and hold it until accepted; sometimes a random gap after
    task automatic send_op(input logic [1:0] op, input logic [7:0] b, input logic [2:0] k);
        in_ch.valid       <= 1'b1;
        in_ch.operation   <= op;
        in_ch.rx_byte     <= b;
        in_ch.module_kind <= k;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        sent++;
        if (sent % ($urandom_range(3, 12)) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
    endtask

    function automatic logic [7:0] hex_of(input logic [3:0] n);
        return (n <= 4'd9) ? 8'h30 + 8'(n) : 8'h37 + 8'(n);
    endfunction

    function automatic int len_of(input logic [2:0] k);
        case (k)
            hfcu_pkg::KIND_DCNT: return 11;
            hfcu_pkg::KIND_DIG:  return 7;
            hfcu_pkg::KIND_CUR:  return 22;
            hfcu_pkg::KIND_RTD:  return 12;
            default:             return 5;
        endcase
    endfunction

    // Send a full window: start, bytes with a valid CRC (optionally broken), end
    task automatic send_frame(input logic [2:0] k, input int mode, input int extra);
        logic [7:0]  fr[64];
        logic [15:0] crc;
        int          len;
        len = len_of(k);
        foreach (fr[i]) fr[i] = 8'($urandom_range(0, 255));
        fr[0] = ":";
        for (int i = 1; i <= len - 4; i++)
            fr[i] = (mode == 2) ? 8'($urandom) : hex_of(4'($urandom));
        crc = 16'hFFFF;
        for (int i = 1; i <= len - 4; i++) begin
            crc = crc ^ 16'(fr[i]);
            for (int j = 0; j < 8; j++) crc = crc[0] ? ((crc >> 1) ^ 16'hA001) : (crc >> 1);
        end
        for (int i = 0; i < 4; i++) fr[len - 3 + i] = hex_of(4'(crc >> (12 - 4 * i)));
        if (mode == 1) fr[len - 3 + $urandom_range(0, 3)] ^= 8'h01;
        send_op(hfcu_pkg::OP_START, 8'($urandom), k);
        for (int i = 0; i <= len + extra && i < 64; i++)
            send_op(hfcu_pkg::OP_BYTE, fr[i], 3'($urandom));
        send_op(hfcu_pkg::OP_END, 8'($urandom), 3'($urandom));
    endtask

    // Pause the sender until nothing is outstanding
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    initial begin
        int r;
        cycle_cnt         = 0;
        sent              = 0;
        hold_off          = 1'b0;
        i_rst_n           = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.operation   = hfcu_pkg::OP_START;
        in_ch.rx_byte     = 8'h00;
        in_ch.module_kind = 3'd0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: every kind, good and bad CRC, overflow, bare and repeated end
        send_op(hfcu_pkg::OP_END, 8'hFF, 3'd7);
        send_frame(hfcu_pkg::KIND_DCNT, 0, 0);
        send_frame(hfcu_pkg::KIND_DIG, 1, 0);
        send_op(hfcu_pkg::OP_END, 8'h00, 3'd0);
        send_frame(hfcu_pkg::KIND_CUR, 2, 0);
        send_frame(hfcu_pkg::KIND_RTD, 0, 20);
        send_frame(3'd0, 0, 0);
        send_frame(3'd7, 1, 0);
        send_op(hfcu_pkg::OP_ROUND, 8'hFF, 3'd7);
        drain();

        // Long receiver hold-off while frames keep coming
        hold_off = 1'b1;
        for (int i = 0; i < 2; i++) send_frame(hfcu_pkg::KIND_CUR, 0, 0);
        drain();

        // Random: mostly well-formed frames, some noise and rewinds
        for (int i = 0; i < 2; i++) begin
            r = $urandom_range(0, 9);
            if (r < 7) send_frame(3'($urandom_range(1, 4)), $urandom_range(0, 2) == 0, 0);
            else if (r == 7) send_op(hfcu_pkg::OP_ROUND, 8'($urandom), 3'($urandom));
            else if (r == 8) send_op(2'($urandom), 8'($urandom), 3'($urandom));
            else send_frame(3'($urandom_range(0, 7)), $urandom_range(0, 2), $urandom_range(0, 25));
            if (i == 0) drain();
        end

        drain();
        if (fail_count == 0) begin
            $display("hex_frame_crc_unpacker_test: PASS");
        end else begin
            $display("hex_frame_crc_unpacker_test: FAIL");
        end
        $finish;
    end

endmodule
